>>> src/midpoint_circle_cell_indexer_defines.svh
// Assertion macros shared by the checker of the circle cell indexer.
`ifndef MIDPOINT_CIRCLE_CELL_INDEXER_DEFINES_SVH
`define MIDPOINT_CIRCLE_CELL_INDEXER_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent.
`define MCCI_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define MCCI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/mcci_pkg.sv
`default_nettype none

package mcci_pkg;

    // Grid and loop constants
    localparam int ROW_STRIDE      = 20;
    localparam int RADIUS_INT_BITS = 6;
    localparam int MAX_STEPS       = 46;
    localparam int CELL_W          = 14;
    localparam int DEC_W           = 12;
    localparam int COORD_W         = 8;
    localparam int RAW_W           = 10;
    localparam int FRAC_BITS       = 4;

    // Derived widths
    localparam int RAD_W   = RADIUS_INT_BITS;
    localparam int RAD_MAX = (1 << RADIUS_INT_BITS) - 1;
    localparam int RND_W   = RAW_W - FRAC_BITS + 1;
    localparam int CMP_W   = (RAD_W > RND_W) ? RAD_W : RND_W;
    localparam int CNT_W   = $clog2(MAX_STEPS + 1);
    localparam int NUM_CELLS = 8;

    // Decision variable constants
    localparam int DEC_INIT   = 3;
    localparam int DEC_INC_LO = 6;
    localparam int DEC_INC_HI = 10;

    typedef logic [CELL_W-1:0]       cell_t;
    typedef logic [RAD_W-1:0]        rad_t;
    typedef logic [RND_W-1:0]        rnd_t;
    typedef logic [CMP_W-1:0]        cmp_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic signed [DEC_W-1:0] dec_t;
    typedef logic signed [RAD_W:0]   off_t;

    // Loop step handed from the sequencer to the output stage
    typedef struct packed {
        rad_t  dx;
        rad_t  dy;
        cell_t sdx;
        cell_t sdy;
        logic  last;
    } step_t;

endpackage

`default_nettype wire

>>> src/mcci_stepper.sv
`default_nettype none

module mcci_stepper (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [mcci_pkg::COORD_W-1:0] center_x,
    input  logic [mcci_pkg::COORD_W-1:0] center_y,
    input  logic [mcci_pkg::RAW_W-1:0]   radius_q4,
    input  logic                         fire,
    output logic                         busy,
    output mcci_pkg::cell_t              base,
    output mcci_pkg::step_t              step
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t           state_reg, state_next;
    mcci_pkg::rad_t   dx_reg, dx_next;
    mcci_pkg::rad_t   dy_reg, dy_next;
    mcci_pkg::dec_t   dec_reg, dec_next;
    mcci_pkg::cell_t  sdx_reg, sdx_next;
    mcci_pkg::cell_t  sdy_reg, sdy_next;
    mcci_pkg::cell_t  base_reg, base_next;
    mcci_pkg::cnt_t   cnt_reg, cnt_next;

    mcci_pkg::rnd_t   r_round;
    mcci_pkg::rad_t   r_sat;
    logic             dec_neg;
    mcci_pkg::dec_t   dec_sub;
    mcci_pkg::dec_t   dec_add;
    mcci_pkg::off_t   dx_inc;
    mcci_pkg::off_t   dy_upd;
    mcci_pkg::cnt_t   cnt_inc;
    logic             last;

    // Round the radius half up and saturate
    always_comb
    begin
        r_round = mcci_pkg::rnd_t'((11'(radius_q4) + 11'd8) >> mcci_pkg::FRAC_BITS);
        if (mcci_pkg::cmp_t'(r_round) > mcci_pkg::cmp_t'(mcci_pkg::RAD_MAX))
        begin
            r_sat = mcci_pkg::rad_t'(mcci_pkg::RAD_MAX);
        end
        else
        begin
            r_sat = mcci_pkg::rad_t'(r_round);
        end
    end

    // Shared decision adder: pick the increment, then one add
    always_comb
    begin
        dec_neg = dec_reg[mcci_pkg::DEC_W-1];
        dec_sub = dec_neg ? mcci_pkg::dec_t'(0) : mcci_pkg::dec_t'(dy_reg);
        dec_add = ((mcci_pkg::dec_t'(dx_reg) - dec_sub) <<< 2)
                + (dec_neg ? mcci_pkg::dec_t'(mcci_pkg::DEC_INC_LO)
                           : mcci_pkg::dec_t'(mcci_pkg::DEC_INC_HI));
        dx_inc  = mcci_pkg::off_t'(dx_reg) + mcci_pkg::off_t'(1);
        dy_upd  = dec_neg ? mcci_pkg::off_t'(dy_reg)
                          : mcci_pkg::off_t'(dy_reg) - mcci_pkg::off_t'(1);
        cnt_inc = cnt_reg + mcci_pkg::cnt_t'(1);
        last    = (dy_upd < dx_inc) || (cnt_inc >= mcci_pkg::cnt_t'(mcci_pkg::MAX_STEPS));
    end

    // Sequence the loop: load on a new circle, advance on each emitted step
    always_comb
    begin
        state_next = state_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dec_next   = dec_reg;
        sdx_next   = sdx_reg;
        sdy_next   = sdy_reg;
        base_next  = base_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (radius_q4 != '0))
                begin
                    state_next = ST_RUN;
                    dx_next    = '0;
                    dy_next    = r_sat;
                    dec_next   = mcci_pkg::dec_t'(mcci_pkg::DEC_INIT)
                               - (mcci_pkg::dec_t'(r_sat) <<< 1);
                    sdx_next   = '0;
                    sdy_next   = mcci_pkg::cell_t'(mcci_pkg::ROW_STRIDE)
                               * mcci_pkg::cell_t'(r_sat);
                    base_next  = mcci_pkg::cell_t'(mcci_pkg::ROW_STRIDE)
                               * mcci_pkg::cell_t'(center_x)
                               + mcci_pkg::cell_t'(center_y);
                    cnt_next   = '0;
                end
            end
            ST_RUN:
            begin
                if (fire)
                begin
                    dx_next  = mcci_pkg::rad_t'(dx_inc);
                    dy_next  = mcci_pkg::rad_t'(dy_upd);
                    dec_next = dec_reg + dec_add;
                    sdx_next = sdx_reg + mcci_pkg::cell_t'(mcci_pkg::ROW_STRIDE);
                    if (!dec_neg)
                    begin
                        sdy_next = sdy_reg - mcci_pkg::cell_t'(mcci_pkg::ROW_STRIDE);
                    end
                    cnt_next = cnt_inc;
                    if (last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dx_reg    <= '0;
            dy_reg    <= '0;
            dec_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dec_reg   <= dec_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Scaled offsets and base index
    always_ff @(posedge clk)
    begin
        sdx_reg  <= sdx_next;
        sdy_reg  <= sdy_next;
        base_reg <= base_next;
    end

    assign busy      = (state_reg == ST_RUN);
    assign base      = base_reg;
    assign step.dx   = dx_reg;
    assign step.dy   = dy_reg;
    assign step.sdx  = sdx_reg;
    assign step.sdy  = sdy_reg;
    assign step.last = last;

endmodule

`default_nettype wire

>>> src/mcci_index.sv
`default_nettype none

module mcci_index (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          load,
    input  logic                                          take,
    input  mcci_pkg::cell_t                               base,
    input  mcci_pkg::step_t                               step,
    output logic                                          valid,
    output logic [mcci_pkg::NUM_CELLS*mcci_pkg::CELL_W-1:0] cells,
    output logic                                          last
);

    logic                                            valid_reg, valid_next;
    logic [mcci_pkg::NUM_CELLS*mcci_pkg::CELL_W-1:0] cells_reg, cells_next;
    logic                                            last_reg, last_next;

    mcci_pkg::cell_t dx_c;
    mcci_pkg::cell_t dy_c;

    // Form the eight mirrored indices from the base and scaled offsets
    always_comb
    begin
        dx_c       = mcci_pkg::cell_t'(step.dx);
        dy_c       = mcci_pkg::cell_t'(step.dy);
        cells_next = {
            base + step.sdx + dy_c,
            base + step.sdy + dx_c,
            base - step.sdy + dx_c,
            base - step.sdx + dy_c,
            base + step.sdx - dy_c,
            base + step.sdy - dx_c,
            base - step.sdy - dx_c,
            base - step.sdx - dy_c
        };
        last_next  = step.last;
        valid_next = load | (valid_reg & ~take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            cells_reg <= cells_next;
            last_reg  <= last_next;
        end
    end

    assign valid = valid_reg;
    assign cells = cells_reg;
    assign last  = last_reg;

endmodule

`default_nettype wire

>>> src/midpoint_circle_cell_indexer.sv
// Midpoint circle cell indexer.
// Slave stream s_*: one item per circle with centre and Q6.4 radius. Master
// stream m_*: one item per loop step holding the eight mirrored cell indices;
// m_tlast marks the final step of a circle.
// The first step passes through the stepper registers and then the output
// register before it appears on m_*. Throughput: one step per cycle while
// m_tready stays high; a circle of rounded radius R gives about R/sqrt(2)+1
// steps (at most 46). The input is taken in a load cycle of its own before
// the loop steps. The rate is set by the single decision adder, which
// advances the loop by one step per cycle while the output is not stalled.
// s_tready is low while a circle runs and returns high at the edge at which
// its last step enters the output register. A zero raw radius is taken and
// gives no output. A radius that rounds to zero gives one step.
// When m_tready is low a held item stays in the output register and the
// loop pauses; nothing is dropped.
// Reset clears the sequencer state and counters and the output valid; the
// block comes up idle and ready.
`default_nettype none

module midpoint_circle_cell_indexer (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [31:0]  s_tdata,   // center_x[7:0], center_y[15:8], radius_q4[25:16]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [111:0] m_tdata,   // cell_a..cell_h, 14 bits each, cell_a lowest
    output logic         m_tlast    // last_step
);

    logic            busy;
    logic            accept;
    logic            fire;
    logic            out_valid;
    mcci_pkg::cell_t base;
    mcci_pkg::step_t step;

    assign s_tready = ~busy;
    assign accept   = s_tvalid & s_tready;
    // Advance the loop whenever the output register is free or being emptied
    assign fire     = busy & (~out_valid | m_tready);

    mcci_stepper u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .center_x  (s_tdata[7:0]),
        .center_y  (s_tdata[15:8]),
        .radius_q4 (s_tdata[25:16]),
        .fire      (fire),
        .busy      (busy),
        .base      (base),
        .step      (step)
    );

    mcci_index u_index (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (fire),
        .take  (m_tready),
        .base  (base),
        .step  (step),
        .valid (out_valid),
        .cells (m_tdata),
        .last  (m_tlast)
    );

    assign m_tvalid = out_valid;

endmodule

`default_nettype wire

>>> src/mcci_checker.sv
`default_nettype none
`include "midpoint_circle_cell_indexer_defines.svh"

module mcci_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic [31:0]  s_tdata,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [111:0] m_tdata,
    input logic         m_tlast
);

    // A stalled item stays put
    `MCCI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "output item changed while stalled")

    // A circle with a nonzero radius blocks the input
    `MCCI_ASSERT_NEXT(a_busy_after_start, s_tvalid && s_tready && (s_tdata[25:16] != 10'd0), !s_tready, "input ready during a circle")

    // A zero radius leaves the block idle
    `MCCI_ASSERT_NEXT(a_idle_after_zero, s_tvalid && s_tready && (s_tdata[25:16] == 10'd0), s_tready, "zero radius started a circle")

    // Mirrored pairs have equal sums (each is twice the centre index)
    `MCCI_ASSERT_SAME(a_mirror_sum, m_tvalid, (mcci_pkg::cell_t'(m_tdata[13:0] + m_tdata[111:98]) == mcci_pkg::cell_t'(m_tdata[55:42] + m_tdata[69:56])) && (mcci_pkg::cell_t'(m_tdata[27:14] + m_tdata[97:84]) == mcci_pkg::cell_t'(m_tdata[41:28] + m_tdata[83:70])), "mirrored indices inconsistent")

endmodule

bind midpoint_circle_cell_indexer mcci_checker u_mcci_checker (.*);

`default_nettype wire
